[rtl/kwq_pkg.sv]
// Package for the keyed removal wait queue: item types, codes and defaults.
package kwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int FIELD_BITS      = 32;
    localparam int OCC_BITS        = 5;

    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_LOOK = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [FIELD_BITS-1:0] resv_code;
        logic [FIELD_BITS-1:0] resource_key;
        logic [FIELD_BITS-1:0] date_key;
        logic [FIELD_BITS-1:0] holder_word;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] out_resv_code;
        logic [FIELD_BITS-1:0] out_resource_key;
        logic [FIELD_BITS-1:0] out_date_key;
        logic [FIELD_BITS-1:0] out_holder_word;
        logic                  queue_empty;
        logic [OCC_BITS-1:0]   occupancy;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESULT
    } state_t;

endpackage

[rtl/keyed_removal_wait_queue_top.sv]
// Keyed removal wait queue: ordered entry memory with keyed search and gap closing.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------
//  request | req_valid | req_stall | req (req_t)
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)
//
// Enqueue, full, empty and bad request types go straight from idle to the result state.
// Dequeue and lookup walk the entry memory one read per cycle until a hit or the
// last entry; a dequeue then shifts the n - 1 - i entries behind the hit at slot i
// through the single read and write port and lowers the count.
// Reset clears the count and control; memory contents are left undefined.
// One item is worked at a time; a result stalled in the output register holds
// back only the next result, not the next request.
module keyed_removal_wait_queue_top #(
    parameter int QUEUE_DEPTH = kwq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = kwq_pkg::KEY_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  kwq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kwq_pkg::rsp_t rsp
);
    import kwq_pkg::*;

    localparam int SW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int EW = 3 * SW + FIELD_BITS;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int DATE_LO = FIELD_BITS;
    localparam int RES_LO  = FIELD_BITS + SW;
    localparam int CODE_LO = FIELD_BITS + 2 * SW;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic [IW-1:0] mem_ra;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ra_reg, ra_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [1:0]    type_reg, type_next;
    logic [SW-1:0] code_reg, code_next;
    logic [SW-1:0] res_reg, res_next;
    logic [SW-1:0] date_reg, date_next;
    logic [1:0]    stat_reg, stat_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          hit;
    logic          last;
    logic          out_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ra_reg        <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ra_reg        <= ra_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        type_reg <= type_next;
        code_reg <= code_next;
        res_reg  <= res_next;
        date_reg <= date_next;
        stat_reg <= stat_next;
        ent_reg  <= ent_next;
        rsp_reg  <= rsp_next;
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign hit = (type_reg == REQ_DEQ)
               ? (rd_data_reg[RES_LO +: SW] == res_reg && rd_data_reg[DATE_LO +: SW] == date_reg)
               : (rd_data_reg[CODE_LO +: SW] == code_reg);
    assign last = (CW'(pidx_reg) == cnt_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ra_next        = ra_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        type_next      = type_reg;
        code_next      = code_reg;
        res_next       = res_reg;
        date_next      = date_reg;
        stat_next      = stat_reg;
        ent_next       = ent_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_wa         = cnt_reg[IW-1:0];
        mem_wd         = {req.resv_code[SW-1:0], req.resource_key[SW-1:0],
                          req.date_key[SW-1:0], req.holder_word};
        mem_ra         = ra_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    type_next = req.req_type;
                    code_next = req.resv_code[SW-1:0];
                    res_next  = req.resource_key[SW-1:0];
                    date_next = req.date_key[SW-1:0];
                    ent_next  = '0;
                    ra_next   = '0;
                    stat_next = STAT_MISS;
                    state_next = ST_RESULT;
                    case (req.req_type)
                        REQ_ENQ:
                        begin
                            if (cnt_reg == CW'(QUEUE_DEPTH))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                cnt_next  = cnt_reg + CW'(1);
                                stat_next = STAT_DONE;
                            end
                        end
                        REQ_DEQ, REQ_LOOK:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_MISS;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (ra_reg < cnt_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ra_reg[IW-1:0];
                    ra_next   = ra_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        pend_next = 1'b0;
                        if (type_reg == REQ_DEQ)
                        begin
                            ent_next   = rd_data_reg;
                            ra_next    = CW'(pidx_reg) + CW'(1);
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            stat_next  = STAT_DONE;
                            state_next = ST_RESULT;
                        end
                    end
                    else if (last)
                    begin
                        pend_next  = 1'b0;
                        stat_next  = STAT_MISS;
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pidx_reg;
                    mem_wd = rd_data_reg;
                end
                if (ra_reg < cnt_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = IW'(ra_reg - CW'(1));
                    ra_next   = ra_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    stat_next  = STAT_DONE;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = stat_reg;
                    rsp_next.out_resv_code    = FIELD_BITS'(ent_reg[CODE_LO +: SW]);
                    rsp_next.out_resource_key = FIELD_BITS'(ent_reg[RES_LO +: SW]);
                    rsp_next.out_date_key     = FIELD_BITS'(ent_reg[DATE_LO +: SW]);
                    rsp_next.out_holder_word  = ent_reg[FIELD_BITS-1:0];
                    rsp_next.queue_empty      = (cnt_reg == '0);
                    rsp_next.occupancy        = OCC_BITS'(cnt_reg);
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/kwq_checker.sv]
// Port-level checker for the keyed removal wait queue, bound to the top level.
module kwq_checker #(
    parameter int QUEUE_DEPTH = kwq_pkg::QUEUE_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input kwq_pkg::rsp_t rsp
);
    import kwq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while an item is in work");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (QUEUE_DEPTH < 32) |-> rsp.queue_empty == (rsp.occupancy == '0))
        else $error("empty flag disagrees with occupancy");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STAT_DONE |->
            rsp.out_resv_code == '0 && rsp.out_resource_key == '0 &&
            rsp.out_date_key == '0 && rsp.out_holder_word == '0)
        else $error("entry fields set on a failed request");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.occupancy == OCC_BITS'(QUEUE_DEPTH))
        else $error("full status below capacity");

endmodule

bind keyed_removal_wait_queue_top kwq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_kwq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[tb/keyed_removal_wait_queue_top_tb.sv]
// Testbench for the keyed removal wait queue: directed and random items, local queue model.
`timescale 1ns / 100ps

module keyed_removal_wait_queue_top_tb;

    import kwq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic [31:0] held_code [QUEUE_DEPTH];
    logic [31:0] held_res [QUEUE_DEPTH];
    logic [31:0] held_date [QUEUE_DEPTH];
    logic [31:0] held_word [QUEUE_DEPTH];
    int held_count = 0;

    rsp_t pending_rsp [$];
    int mismatch_count = 0;
    bit no_idle = 1'b0;
    int hold_cycles = 0;

    logic [31:0] res_pool [4];
    logic [31:0] date_pool [3];

    keyed_removal_wait_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic rsp_t queue_predict(req_t r);
        rsp_t o;
        int i;
        int hit;
        o = '0;
        o.status = STAT_MISS;
        hit = -1;
        if (r.req_type == REQ_ENQ)
        begin
            if (held_count >= QUEUE_DEPTH)
                o.status = STAT_FULL;
            else
            begin
                held_code[held_count] = r.resv_code;
                held_res[held_count] = r.resource_key;
                held_date[held_count] = r.date_key;
                held_word[held_count] = r.holder_word;
                held_count++;
                o.status = STAT_DONE;
            end
        end
        else if (r.req_type == REQ_DEQ)
        begin
            for (i = 0; i < held_count; i++)
                if (hit < 0 && held_res[i] == r.resource_key && held_date[i] == r.date_key)
                    hit = i;
            if (hit >= 0)
            begin
                o.status = STAT_DONE;
                o.out_resv_code = held_code[hit];
                o.out_resource_key = held_res[hit];
                o.out_date_key = held_date[hit];
                o.out_holder_word = held_word[hit];
                for (i = hit; i + 1 < held_count; i++)
                begin
                    held_code[i] = held_code[i + 1];
                    held_res[i] = held_res[i + 1];
                    held_date[i] = held_date[i + 1];
                    held_word[i] = held_word[i + 1];
                end
                held_count--;
            end
        end
        else if (r.req_type == REQ_LOOK)
        begin
            for (i = 0; i < held_count; i++)
                if (held_code[i] == r.resv_code)
                    o.status = STAT_DONE;
        end
        o.queue_empty = (held_count == 0);
        o.occupancy = held_count[OCC_BITS-1:0];
        return o;
    endfunction

    function automatic req_t make_req(logic [1:0] t, logic [31:0] c, logic [31:0] k,
                                      logic [31:0] d, logic [31:0] w);
        req_t r;
        r.req_type = t;
        r.resv_code = c;
        r.resource_key = k;
        r.date_key = d;
        r.holder_word = w;
        return r;
    endfunction

    // keys mostly come from small pools so that dequeues hit and duplicates occur
    function automatic req_t random_req(int enq_pct);
        req_t r;
        int roll;
        int slot;
        roll = $urandom_range(0, 99);
        r = make_req(REQ_ENQ, $urandom, res_pool[$urandom_range(0, 3)],
                     date_pool[$urandom_range(0, 2)], $urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            r.resource_key = $urandom;
            r.date_key = $urandom;
        end
        if (roll >= 97)
            r.req_type = REQ_UNUSED;
        else if (roll >= enq_pct)
        begin
            slot = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
            if (roll - enq_pct < (97 - enq_pct) * 2 / 3)
            begin
                r.req_type = REQ_DEQ;
                if (held_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    r.resource_key = held_res[slot];
                    r.date_key = held_date[slot];
                end
            end
            else
            begin
                r.req_type = REQ_LOOK;
                if (held_count > 0 && $urandom_range(0, 9) < 6)
                    r.resv_code = held_code[slot];
            end
        end
        return r;
    endfunction

    task automatic send_item(req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp.push_back(queue_predict(r));
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() > 0);
    endtask

    // receiver: random hold-off per item, or a long one on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
                gap = hold_cycles;
            else
                gap = no_idle ? 0 : $urandom_range(0, 17);
            hold_cycles = 0;
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid && hold_cycles == 0);
        end
    end

    function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0h, actual %0h", name, expv, actv);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result item with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("out_resv_code", want.out_resv_code, rsp.out_resv_code);
                check_field("out_resource_key", want.out_resource_key, rsp.out_resource_key);
                check_field("out_date_key", want.out_date_key, rsp.out_date_key);
                check_field("out_holder_word", want.out_holder_word, rsp.out_holder_word);
                check_field("queue_empty", 32'(want.queue_empty), 32'(rsp.queue_empty));
                check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
            end
        end
    end

    task automatic test_directed();
        logic [31:0] ka, kb, kc, ke, kf;
        int i;
        ka = $urandom;
        kb = $urandom;
        kc = $urandom;
        ke = $urandom;
        kf = $urandom;
        send_item(make_req(REQ_LOOK, '0, '0, '0, '0));
        send_item(make_req(REQ_DEQ, '0, '0, '0, '0));
        send_item(make_req(REQ_ENQ, '0, '0, '0, '0));
        send_item(make_req(REQ_ENQ, '1, '1, '1, '1));
        for (i = 2; i < QUEUE_DEPTH - 1; i++)
            send_item(make_req(REQ_ENQ, $urandom, i[0] ? ka : kb, kc, $urandom));
        send_item(make_req(REQ_ENQ, $urandom, ke, kf, $urandom));
        // full
        send_item(make_req(REQ_ENQ, $urandom, ka, kc, $urandom));
        // oldest of several matches
        send_item(make_req(REQ_DEQ, $urandom, ka, kc, $urandom));
        // resource matches, date does not
        send_item(make_req(REQ_DEQ, $urandom, ka, kf, $urandom));
        // tail entry
        send_item(make_req(REQ_DEQ, '0, ke, kf, '0));
        send_item(make_req(REQ_UNUSED, '1, '1, '1, '1));
        send_item(make_req(REQ_LOOK, '1, '0, '0, '0));
        // head entry
        send_item(make_req(REQ_DEQ, '1, '0, '0, '1));
        send_item(make_req(REQ_DEQ, '0, '1, '1, '0));
        wait_all_results();
    endtask

    task automatic test_backpressure_fill();
        int i;
        hold_cycles = 400;
        no_idle = 1'b1;
        for (i = 0; i < 24; i++)
            send_item(random_req(60));
        no_idle = 1'b0;
        wait_all_results();
    endtask

    task automatic test_no_idle_burst();
        int i;
        no_idle = 1'b1;
        for (i = 0; i < 60; i++)
            send_item(random_req(50));
        no_idle = 1'b0;
        wait_all_results();
    endtask

    task automatic test_random_mix();
        int blk;
        int i;
        for (blk = 0; blk < 13; blk++)
            for (i = 0; i < 50; i++)
                send_item(random_req(blk[0] ? 25 : 75));
        wait_all_results();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < 4; i++)
            res_pool[i] = $urandom;
        for (i = 0; i < 3; i++)
            date_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure_fill();
        test_no_idle_burst();
        test_random_mix();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/kwq_pkg.sv
rtl/keyed_removal_wait_queue_top.sv
rtl/kwq_checker.sv
tb/keyed_removal_wait_queue_top_tb.sv
